[rtl/gn3d_pkg.sv]
// shared constants and the permutation table for the gradient noise block
package gn3d_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int COORD_W = 32;
	localparam int NOISE_W = 18;
	localparam int CELL_W = 8;
	localparam int HASH_W = 8;
	localparam int GRAD_W = 4;

	localparam logic signed [NOISE_W-1:0] NOISE_MAX = 18'sh1FFFF;
	localparam logic signed [NOISE_W-1:0] NOISE_MIN = -18'sh20000;

	localparam logic [7:0] PERM_ROM [256] = '{
		8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
		8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
		8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
		8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
		8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
		8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
		8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
		8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
		8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
		8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
		8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
		8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
		8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
		8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
		8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
		8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
		8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
		8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
		8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
		8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
		8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
		8'd215,8'd61,8'd156,8'd180};

	localparam logic [GRAD_W-1:0] GR_12 = 4'd12;
	localparam logic [GRAD_W-1:0] GR_14 = 4'd14;

	function automatic logic [7:0] perm(input logic [7:0] i);
		return PERM_ROM[i];
	endfunction

endpackage

[rtl/gn3d_hash.sv]
// three-stage corner hash through the permutation table
module gn3d_hash (
	input  logic clk,
	input  logic [7:0] cx,
	input  logic [7:0] cy,
	input  logic [7:0] cz,
	output logic [3:0] grad [8]
);
	import gn3d_pkg::*;

	logic [7:0] a_s1, b_s1, cy_s1, cz_s1, cz_s2;
	logic [7:0] aa_s2, ab_s2, ba_s2, bb_s2;
	logic [7:0] pa, pb;

	assign pa = perm(cx);
	assign pb = perm(cx + 8'd1);

	always_ff @(posedge clk) begin
		a_s1 <= pa + cy;
		b_s1 <= pb + cy;
		cz_s1 <= cz;
		cy_s1 <= cy;
		aa_s2 <= perm(a_s1) + cz_s1;
		ab_s2 <= perm(a_s1 + 8'd1) + cz_s1;
		ba_s2 <= perm(b_s1) + cz_s1;
		bb_s2 <= perm(b_s1 + 8'd1) + cz_s1;
		cz_s2 <= cz_s1;
		// corner order: z-low aa ba ab bb then z-high
		grad[0] <= PERM_ROM[aa_s2][3:0];
		grad[1] <= PERM_ROM[ba_s2][3:0];
		grad[2] <= PERM_ROM[ab_s2][3:0];
		grad[3] <= PERM_ROM[bb_s2][3:0];
		grad[4] <= PERM_ROM[8'(aa_s2 + 8'd1)][3:0];
		grad[5] <= PERM_ROM[8'(ba_s2 + 8'd1)][3:0];
		grad[6] <= PERM_ROM[8'(ab_s2 + 8'd1)][3:0];
		grad[7] <= PERM_ROM[8'(bb_s2 + 8'd1)][3:0];
	end

	logic unused_s;
	assign unused_s = ^{cy_s1, cz_s2};
endmodule

[rtl/gn3d_fade.sv]
// three-stage quintic fade curve, one multiplier per stage
module gn3d_fade #(
	parameter int FRAC_BITS = gn3d_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic [FRAC_BITS-1:0] f,
	output logic [FRAC_BITS:0] fade
);
	import gn3d_pkg::*;

	localparam int FW = FRAC_BITS;
	localparam int PW = FW + 5;

	logic [FW-1:0] f_s1, t2_s1, f_s2, t2_s2, t3_s2;
	logic [2*FW-1:0] sq, cu;
	logic signed [PW-1:0] p_s2;
	logic signed [PW+FW:0] prod;

	assign sq = f * f;
	assign cu = t2_s1 * f_s1;
	assign prod = $signed({1'b0, t3_s2}) * p_s2;

	always_ff @(posedge clk) begin
		f_s1 <= f;
		t2_s1 <= sq[2*FW-1:FW];
		f_s2 <= f_s1;
		t2_s2 <= t2_s1;
		t3_s2 <= cu[2*FW-1:FW];
		p_s2 <= PW'(6 * $signed({1'b0, t2_s1})) - PW'(15 * $signed({1'b0, f_s1}))
			+ PW'(10 <<< FW);
		fade <= prod[FW+FW:FW];
	end

	logic unused_s;
	assign unused_s = ^{f_s2, t2_s2, prod[FW-1:0], prod[PW+FW]};
endmodule

[rtl/gn3d_lerp.sv]
// one registered linear interpolation stage
module gn3d_lerp #(
	parameter int W = 20,
	parameter int FRAC_BITS = gn3d_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	input  logic [FRAC_BITS:0] t,
	output logic signed [W-1:0] y
);
	logic signed [W:0] d;
	logic signed [W+FRAC_BITS+1:0] m;

	assign d = (W+1)'(b) - (W+1)'(a);
	assign m = d * $signed({1'b0, t});

	always_ff @(posedge clk) begin
		y <= a + W'(m >>> FRAC_BITS);
	end
endmodule

[rtl/gradient_noise_3d.sv]
// gradient noise 3d top level: the result strobe is start carried through the valid shift register
// throughput one point per cycle; busy is never raised
// pipeline: hash 3 stages alongside fade 3, gradient 1, lerps 3, output 1
// reset clears valid bits and the range mode register; data registers are not reset
module gradient_noise_3d #(
	parameter int FRAC_BITS = gn3d_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [gn3d_pkg::COORD_W-1:0] coord_x,
	input  logic signed [gn3d_pkg::COORD_W-1:0] coord_y,
	input  logic signed [gn3d_pkg::COORD_W-1:0] coord_z,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data,
	output logic done,
	output logic signed [gn3d_pkg::NOISE_W-1:0] noise_value
);
	import gn3d_pkg::*;

	localparam int FW = FRAC_BITS;
	localparam int VW = FW + 4;
	localparam int LAT = 8;

	logic mode_q;
	logic [LAT-1:0] vld_q;
	logic [3:0] grad [8];
	logic [FW:0] u, v, w;
	logic [FW:0] u_s4, v_s4, v_s5, w_s4, w_s5, w_s6;
	logic [FW-1:0] fx_d [3], fy_d [3], fz_d [3];
	logic signed [VW-1:0] g_s4 [8];
	logic signed [VW-1:0] l1 [4];
	logic signed [VW-1:0] l2 [2];
	logic signed [VW-1:0] r_s7;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			vld_q <= '0;
		end else begin
			if (cfg_valid) mode_q <= cfg_data;
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end

	gn3d_hash u_hash (.clk, .cx(coord_x[FW+7:FW]), .cy(coord_y[FW+7:FW]),
		.cz(coord_z[FW+7:FW]), .grad);
	gn3d_fade #(.FRAC_BITS(FW)) u_fx (.clk, .f(coord_x[FW-1:0]), .fade(u));
	gn3d_fade #(.FRAC_BITS(FW)) u_fy (.clk, .f(coord_y[FW-1:0]), .fade(v));
	gn3d_fade #(.FRAC_BITS(FW)) u_fz (.clk, .f(coord_z[FW-1:0]), .fade(w));

	always_ff @(posedge clk) begin
		fx_d[0] <= coord_x[FW-1:0]; fy_d[0] <= coord_y[FW-1:0]; fz_d[0] <= coord_z[FW-1:0];
		for (int i = 1; i < 3; i++) begin
			fx_d[i] <= fx_d[i-1]; fy_d[i] <= fy_d[i-1]; fz_d[i] <= fz_d[i-1];
		end
	end

	function automatic logic signed [VW-1:0] dotg(input logic [3:0] h,
		input logic signed [VW-1:0] x, input logic signed [VW-1:0] y,
		input logic signed [VW-1:0] z);
		logic signed [VW-1:0] a, b;
		a = (h < 4'd8) ? x : y;
		b = (h < 4'd4) ? y : ((h == GR_12 || h == GR_14) ? x : z);
		return (h[0] ? -a : a) + (h[1] ? -b : b);
	endfunction

	always_ff @(posedge clk) begin : grad_stage
		logic signed [VW-1:0] x0, y0, z0, x1, y1, z1;
		x0 = VW'({1'b0, fx_d[2]}); y0 = VW'({1'b0, fy_d[2]}); z0 = VW'({1'b0, fz_d[2]});
		x1 = x0 - (VW'(1) <<< FW); y1 = y0 - (VW'(1) <<< FW); z1 = z0 - (VW'(1) <<< FW);
		g_s4[0] <= dotg(grad[0], x0, y0, z0);
		g_s4[1] <= dotg(grad[1], x1, y0, z0);
		g_s4[2] <= dotg(grad[2], x0, y1, z0);
		g_s4[3] <= dotg(grad[3], x1, y1, z0);
		g_s4[4] <= dotg(grad[4], x0, y0, z1);
		g_s4[5] <= dotg(grad[5], x1, y0, z1);
		g_s4[6] <= dotg(grad[6], x0, y1, z1);
		g_s4[7] <= dotg(grad[7], x1, y1, z1);
		u_s4 <= u; v_s4 <= v; w_s4 <= w;
		v_s5 <= v_s4; w_s5 <= w_s4; w_s6 <= w_s5;
	end

	for (genvar k = 0; k < 4; k++) begin : g_l1
		gn3d_lerp #(.W(VW), .FRAC_BITS(FW)) u_l (.clk, .a(g_s4[2*k]), .b(g_s4[2*k+1]),
			.t(u_s4), .y(l1[k]));
	end
	for (genvar k = 0; k < 2; k++) begin : g_l2
		gn3d_lerp #(.W(VW), .FRAC_BITS(FW)) u_l (.clk, .a(l1[2*k]), .b(l1[2*k+1]),
			.t(v_s5), .y(l2[k]));
	end
	gn3d_lerp #(.W(VW), .FRAC_BITS(FW)) u_l3 (.clk, .a(l2[0]), .b(l2[1]), .t(w_s6),
		.y(r_s7));

	logic signed [VW+16:0] r_m, r_c;
	always_comb begin
		r_m = (VW+17)'(r_s7);
		if (mode_q) begin
			r_m = (r_m >>> 1) + ((VW+17)'(1) <<< (FW-1));
			if (r_m < 0) r_m = '0;
			if (r_m > ((VW+17)'(1) <<< FW)) r_m = (VW+17)'(1) <<< FW;
		end
		if (FW >= 16) r_c = r_m >>> (FW - 16);
		else r_c = r_m <<< (16 - FW);
	end

	always_ff @(posedge clk) begin
		if (r_c > (VW+17)'(NOISE_MAX)) noise_value <= NOISE_MAX;
		else if (r_c < (VW+17)'(NOISE_MIN)) noise_value <= NOISE_MIN;
		else noise_value <= NOISE_W'(r_c);
	end

	// done is the start bit after it has passed through the valid shift register
	assign done = vld_q[LAT-1];

	a_fixed_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##8 done) else $error("result strobe lost");
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy raised");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 8)) else $error("spurious result");
endmodule

[test/gradient_noise_3d_chk.sv]
// checker for the gradient noise block: watches requests, predicts noise values, compares
`timescale 1ns / 1ps
module gradient_noise_3d_chk #(
	parameter int FRAC_BITS = gn3d_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic cfg_data,
	input  logic done,
	input  logic signed [17:0] noise_value,
	output int fail_count,
	output int pending,
	output int results_seen
);
	import gn3d_pkg::*;

	logic unit_mode;
	logic signed [17:0] noise_q[$];

	// floor division by 2^F for signed values
	function automatic longint fl_shift(longint v);
		return v >>> FRAC_BITS;
	endfunction

	function automatic longint fade_curve(longint f);
		longint t2, t3, p;
		t2 = (f * f) >>> FRAC_BITS;
		t3 = (t2 * f) >>> FRAC_BITS;
		p = 6 * t2 - 15 * f + (longint'(10) <<< FRAC_BITS);
		return fl_shift(t3 * p);
	endfunction

	function automatic longint grad_dot(logic [7:0] hsh, longint x, longint y, longint z);
		logic [3:0] h;
		longint u, v;
		h = hsh[3:0];
		u = (h < 8) ? x : y;
		v = (h < 4) ? y : ((h == GR_12 || h == GR_14) ? x : z);
		return (h[0] ? -u : u) + (h[1] ? -v : v);
	endfunction

	function automatic longint blend(longint a, longint b, longint t);
		return a + fl_shift((b - a) * t);
	endfunction

	function automatic logic [7:0] pt(int i);
		return PERM_ROM[i & 255];
	endfunction

	function automatic logic signed [17:0] noise_at(logic [31:0] px, logic [31:0] py,
			logic [31:0] pz, logic mode);
		longint one, fm, x, y, z, x1, y1, z1, u, v, w, lo, hi, r;
		int cx, cy, cz, a, aa, ab, b, ba, bb;
		one = longint'(1) <<< FRAC_BITS;
		fm = one - 1;
		cx = (px >> FRAC_BITS) & 255;
		cy = (py >> FRAC_BITS) & 255;
		cz = (pz >> FRAC_BITS) & 255;
		x = longint'(px) & fm;
		y = longint'(py) & fm;
		z = longint'(pz) & fm;
		u = fade_curve(x);
		v = fade_curve(y);
		w = fade_curve(z);
		x1 = x - one;
		y1 = y - one;
		z1 = z - one;
		a = pt(cx) + cy;
		aa = pt(a) + cz;
		ab = pt(a + 1) + cz;
		b = pt(cx + 1) + cy;
		ba = pt(b) + cz;
		bb = pt(b + 1) + cz;
		lo = blend(blend(grad_dot(pt(aa), x, y, z), grad_dot(pt(ba), x1, y, z), u),
			blend(grad_dot(pt(ab), x, y1, z), grad_dot(pt(bb), x1, y1, z), u), v);
		hi = blend(blend(grad_dot(pt(aa + 1), x, y, z1), grad_dot(pt(ba + 1), x1, y, z1), u),
			blend(grad_dot(pt(ab + 1), x, y1, z1), grad_dot(pt(bb + 1), x1, y1, z1), u), v);
		r = blend(lo, hi, w);
		if (mode) begin
			r = (r >>> 1) + (one >>> 1);
			if (r < 0) r = 0;
			if (r > one) r = one;
		end
		if (FRAC_BITS > 16) r = r >>> (FRAC_BITS - 16);
		else r = r <<< (16 - FRAC_BITS);
		if (r < -131072) r = -131072;
		if (r > 131071) r = 131071;
		return r[17:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_mode <= 1'b0;
			fail_count <= 0;
			results_seen <= 0;
			pending <= 0;
			noise_q.delete();
		end else begin
			if (done) begin
				results_seen <= results_seen + 1;
				if (noise_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result %0d", noise_value);
				end else if (noise_q[0] !== noise_value) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("noise mismatch: expected %0d got %0d", noise_q[0], noise_value);
					void'(noise_q.pop_front());
				end else
					void'(noise_q.pop_front());
			end
			if (start && !busy)
				noise_q.push_back(noise_at(coord_x, coord_y, coord_z, unit_mode));
			if (cfg_valid && cfg_ready)
				unit_mode <= cfg_data;
			pending <= noise_q.size();
		end
	end
endmodule

[test/gradient_noise_3d_tb.sv]
// testbench top for the gradient noise block: stimulus, mode changes and verdict
`timescale 1ns / 1ps
module gradient_noise_3d_tb;
	logic clk, arst_n, start, busy, cfg_valid, cfg_ready, cfg_data, done;
	logic signed [31:0] coord_x, coord_y, coord_z;
	logic signed [17:0] noise_value;
	int fail_count, pending, results_seen, idle_cycles, sent;
	bit timed_out;

	gradient_noise_3d dut (.*);

	gradient_noise_3d_chk chk (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog on cycles without any accepted request or result
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles > 5000) begin
			$display("watchdog: no progress");
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
			3: return {16'($urandom_range(0, 600)), 16'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit gaps);
		while (gaps && $urandom_range(0, 99) < 16) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	task automatic drain_and_set_mode(logic m);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(int n);
		bit gaps;
		for (int i = 0; i < n; i++) begin
			gaps = (i % 200) >= 60;
			send_point(rand_coord(), rand_coord(), rand_coord(), gaps);
		end
	endtask

	initial begin
		logic [31:0] edge_vals[8];
		arst_n = 1'b0;
		start = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		coord_x = '0;
		coord_y = '0;
		coord_z = '0;
		sent = 0;
		edge_vals = '{32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff,
			32'h0000_8000, 32'hff00_0000, 32'h00ff_ffff, 32'h0001_0000};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners, wrapping negative cells and fraction extremes
		for (int i = 0; i < 8; i++)
			send_point(edge_vals[i], edge_vals[(i + 3) % 8], edge_vals[(i + 5) % 8], 1'b0);
		for (int i = 0; i < 8; i++)
			send_point(edge_vals[i], edge_vals[i], edge_vals[i], 1'b1);
		random_phase(400);

		drain_and_set_mode(1'b1);
		for (int i = 0; i < 8; i++)
			send_point(edge_vals[i], edge_vals[(i + 1) % 8], edge_vals[(i + 6) % 8], 1'b1);
		random_phase(350);

		drain_and_set_mode(1'b0);
		random_phase(200);
		drain_and_set_mode(1'b1);
		random_phase(200);

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d points over both range modes, %0d results checked",
			sent, results_seen);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
